[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/hti_pkg.sv]
// ----------------------------------------------------------------------------
// hti_pkg
// Shared types, constants and helpers of the heightmap interpolation block.
// ----------------------------------------------------------------------------
package hti_pkg;

    localparam int MAX_CELLS = 64;
    localparam int FB        = 8;
    localparam int DEPTH     = (MAX_CELLS + 1) * (MAX_CELLS + 1);
    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = 7;
    localparam int HW        = 24;
    localparam int CSW       = 20;
    localparam int HFW       = 16;
    localparam int NUM_W     = 36;
    localparam int DEN_W     = CSW + 1;
    localparam int QDEPTH    = 2;
    localparam int QAW       = 1;
    localparam int SUM_W     = 10;

    // Reciprocal of 3 for the channel average: exact for values below 2^19
    localparam int RECIP_SH  = 19;
    localparam logic [17:0] RECIP3 = 18'((2 ** RECIP_SH + 1) / 3);

    localparam logic signed [HW-1:0] H_MAX = 24'sh7FFFFF;
    localparam logic signed [HW-1:0] H_MIN = -24'sh800000;

    // Register indexes
    localparam logic [2:0] REG_COLS = 3'd0;
    localparam logic [2:0] REG_ROWS = 3'd1;
    localparam logic [2:0] REG_CS   = 3'd2;
    localparam logic [2:0] REG_HF   = 3'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Effective configuration
    typedef struct packed {
        logic [CW-1:0]  cols;
        logic [CW-1:0]  rows;
        logic [CSW-1:0] cs;
        logic [HFW-1:0] hf;
    } t_cfg;

    // One classified item in the queue
    typedef struct packed {
        logic              is_query;
        logic [SUM_W-1:0]  sum;
        logic              wr_ok;
        logic [AW-1:0]     widx;
        logic signed [HW-1:0] x;
        logic signed [HW-1:0] z;
    } t_job;

    // Clamp a cell count to 1..MAX_CELLS
    function automatic logic [CW-1:0] eff_cells(input logic [CW-1:0] v);
        logic [CW-1:0] r;
        if (v == '0) begin
            r = CW'(1);
        end else if (v > CW'(MAX_CELLS)) begin
            r = CW'(MAX_CELLS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[sv/hti_front.sv]
// ----------------------------------------------------------------------------
// hti_front
// Accepts items, classifies loads and queries, and queues them for the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hti_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hti_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [hti_pkg::CW-1:0]        i_vertex_row,
    input  logic [hti_pkg::CW-1:0]        i_vertex_column,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    input  logic signed [hti_pkg::HW-1:0] i_query_x,
    input  logic signed [hti_pkg::HW-1:0] i_query_z,
    output logic                          o_job_valid,
    output hti_pkg::t_job                 o_job,
    input  logic                          i_pop
);

    hti_pkg::t_job r_q [hti_pkg::QDEPTH];
    logic [hti_pkg::QAW-1:0] r_wp, r_rp;
    logic [hti_pkg::QAW:0]   r_cnt;
    hti_pkg::t_job w_job;
    logic          w_push;
    logic [13:0]   w_idx;

    assign o_stall     = (r_cnt == (hti_pkg::QAW+1)'(hti_pkg::QDEPTH));
    assign w_push      = i_valid && !o_stall;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];

    // Classify: channel sum, write target and grid check for loads
    always_comb begin
        w_idx = 14'(i_vertex_row) * 14'(i_cfg.cols + 7'd1) + 14'(i_vertex_column);
        w_job.is_query = (i_opcode == hti_pkg::OP_QUERY);
        w_job.sum      = 10'(i_red) + 10'(i_green) + 10'(i_blue);
        w_job.wr_ok    = (i_vertex_row <= i_cfg.rows) && (i_vertex_column <= i_cfg.cols);
        w_job.widx     = w_idx[hti_pkg::AW-1:0];
        w_job.x        = i_query_x;
        w_job.z        = i_query_z;
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `ASSERT_IMPL(a_cnt_max, 1'b1, r_cnt <= (hti_pkg::QAW+1)'(hti_pkg::QDEPTH))
    `ASSERT_IMPL(a_pop_nonempty, i_pop, r_cnt != '0)
    `ASSERT_NEXT(a_push_count, w_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1)

endmodule

[sv/hti_div.sv]
// ----------------------------------------------------------------------------
// hti_div
// Serial restoring divider, one quotient bit per cycle, floor rounding.
// ----------------------------------------------------------------------------
module hti_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [hti_pkg::NUM_W-1:0]    i_num,
    input  logic [hti_pkg::DEN_W-1:0]           i_den,
    output logic                                o_done,
    output logic signed [hti_pkg::NUM_W-1:0]    o_quot
);

    localparam int CNTW = $clog2(hti_pkg::NUM_W + 1);

    logic                         r_busy, r_done, r_neg;
    logic [CNTW-1:0]              r_cnt;
    logic [hti_pkg::NUM_W-1:0]    r_q;
    logic [hti_pkg::DEN_W-1:0]    r_rem;
    logic [hti_pkg::DEN_W-1:0]    r_den;
    logic [hti_pkg::DEN_W:0]      w_rs;
    logic                         w_bit;
    logic [hti_pkg::DEN_W:0]      w_rn;
    logic [hti_pkg::NUM_W-1:0]    w_adj;

    // One shift-subtract step
    always_comb begin
        w_rs  = {r_rem, r_q[hti_pkg::NUM_W-1]};
        w_bit = (w_rs >= {1'b0, r_den});
        w_rn  = w_bit ? (w_rs - {1'b0, r_den}) : w_rs;
    end

    // Floor for negative dividends
    assign w_adj  = r_q + hti_pkg::NUM_W'(r_rem != '0);
    assign o_quot = r_neg ? -$signed(w_adj) : $signed(r_q);
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNTW'(hti_pkg::NUM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(hti_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[hti_pkg::NUM_W-1];
            r_q   <= i_num[hti_pkg::NUM_W-1] ? hti_pkg::NUM_W'(-i_num)
                                             : hti_pkg::NUM_W'(i_num);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[hti_pkg::NUM_W-2:0], w_bit};
            r_rem <= w_rn[hti_pkg::DEN_W-1:0];
        end
    end

endmodule

[sv/hti_back.sv]
// ----------------------------------------------------------------------------
// hti_back
// Carries out queued items: load height, grid division, four corner reads
// from the height memory, triangle interpolation and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hti_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hti_pkg::t_cfg                 i_cfg,
    input  logic                          i_job_valid,
    input  hti_pkg::t_job                 i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [hti_pkg::HW-1:0] o_height_out,
    output logic                          o_was_query
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_LAVG = 10'b0000000010,
        S_LMUL = 10'b0000000100,
        S_PREP = 10'b0000001000,
        S_DST  = 10'b0000010000,
        S_DIV  = 10'b0000100000,
        S_IDX  = 10'b0001000000,
        S_READ = 10'b0010000000,
        S_MUL  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    hti_pkg::t_job r_job;

    // Memory
    logic signed [hti_pkg::HW-1:0] r_mem [hti_pkg::DEPTH];
    logic signed [hti_pkg::HW-1:0] r_mq;
    logic                          w_we;
    logic [hti_pkg::AW-1:0]        w_raddr;

    logic [15:0]                   r_avg;
    logic signed [hti_pkg::HW-1:0] r_h;
    logic [26:0]                   r_w, r_ht;
    logic signed [hti_pkg::NUM_W-1:0] w_nx, w_nz, w_gx, w_gz, r_gx, r_gz;
    logic [hti_pkg::DEN_W-1:0]     w_den;
    logic                          w_dstart, w_dxdone, w_dzdone;
    logic [hti_pkg::CSW-1:0]       w_cs;
    logic [7:0]                    w_cp1;
    logic [12:0]                   w_count;

    // Corner indexing
    logic signed [27:0]            w_col, w_row;
    logic signed [37:0]            r_idxa, w_idxk;
    logic [7:0]                    r_fx, r_fz;
    logic                          r_row0, r_row1, r_col0, r_col1;
    logic [2:0]                    r_rk;
    logic [1:0]                    r_rkd;
    logic                          r_rv, r_rok, w_ok;
    logic signed [hti_pkg::HW-1:0] r_cn [4];

    // Interpolation
    logic                          r_sum_st;
    logic signed [34:0]            r_pu, r_pv;
    logic signed [hti_pkg::HW-1:0] r_p;
    logic                          w_upper;
    logic signed [24:0]            w_u, w_v;
    logic [8:0]                    w_wu, w_wv;
    logic signed [36:0]            w_acc;
    logic signed [28:0]            w_hq;
    logic [31:0]                   w_lprod;
    logic [35:0]                   w_aprod;

    logic r_ov, w_ofree;
    logic signed [hti_pkg::HW-1:0] r_oh;
    logic r_oq;

    assign w_cs    = (i_cfg.cs == '0) ? hti_pkg::CSW'(1) : i_cfg.cs;
    assign w_den   = {w_cs, 1'b0};
    assign w_cp1   = 8'(i_cfg.cols) + 8'd1;
    assign w_count = 13'(w_cp1) * 13'(8'(i_cfg.rows) + 8'd1);
    assign w_ofree = !r_ov || !i_stall;
    assign o_pop   = (r_state == S_IDLE) && i_job_valid;
    assign w_dstart = (r_state == S_DST);

    // Grid numerators: centre the grid, scale by one cell unit
    always_comb begin
        w_nx = $signed({28'($signed({r_job.x, 1'b0})) + $signed({1'b0, r_w}), 8'd0});
        w_nz = $signed({$signed({1'b0, r_ht}) - 28'($signed({r_job.z, 1'b0})), 8'd0});
    end

    hti_div u_divx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_nx),
        .i_den   (w_den),
        .o_done  (w_dxdone),
        .o_quot  (w_gx)
    );

    hti_div u_divz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_nz),
        .i_den   (w_den),
        .o_done  (w_dzdone),
        .o_quot  (w_gz)
    );

    // Corner k address and validity
    always_comb begin
        w_col = 28'(r_gx >>> hti_pkg::FB);
        w_row = 28'(r_gz >>> hti_pkg::FB);
        case (r_rk)
            3'd0: begin
                w_idxk = r_idxa;
                w_ok   = r_row0 && r_col0;
            end
            3'd1: begin
                w_idxk = r_idxa + 38'sd1;
                w_ok   = r_row0 && r_col1;
            end
            3'd2: begin
                w_idxk = r_idxa + 38'($signed({1'b0, w_cp1}));
                w_ok   = r_row1 && r_col0;
            end
            3'd3: begin
                w_idxk = r_idxa + 38'($signed({1'b0, w_cp1})) + 38'sd1;
                w_ok   = r_row1 && r_col1;
            end
            default: begin
                w_idxk = r_idxa;
                w_ok   = 1'b0;
            end
        endcase
        w_ok    = w_ok && (w_idxk < 38'($signed({1'b0, w_count})));
        w_raddr = w_idxk[hti_pkg::AW-1:0];
    end

    // Triangle select and weights
    always_comb begin
        w_upper = (9'(r_fx) + 9'(r_fz)) < 9'd256;
        if (w_upper) begin
            w_u  = 25'(r_cn[1]) - 25'(r_cn[0]);
            w_v  = 25'(r_cn[2]) - 25'(r_cn[0]);
            w_wu = 9'(r_fx);
            w_wv = 9'(r_fz);
        end else begin
            w_u  = 25'(r_cn[2]) - 25'(r_cn[3]);
            w_v  = 25'(r_cn[1]) - 25'(r_cn[3]);
            w_wu = 9'd256 - 9'(r_fx);
            w_wv = 9'd256 - 9'(r_fz);
        end
        w_acc = 37'($signed({r_p, 8'd0})) + 37'(r_pu) + 37'(r_pv);
        w_hq  = 29'(w_acc >>> hti_pkg::FB);
    end

    assign w_aprod = 36'({r_job.sum, 8'd0}) * 36'(hti_pkg::RECIP3);
    assign w_lprod = 32'(r_avg) * 32'(i_cfg.hf);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_job_valid) n_state = i_job.is_query ? S_PREP : S_LAVG;
            S_LAVG: n_state = S_LMUL;
            S_LMUL: n_state = S_DONE;
            S_PREP: n_state = S_DST;
            S_DST:  n_state = S_DIV;
            S_DIV:  if (w_dxdone) n_state = S_IDX;
            S_IDX:  n_state = S_READ;
            S_READ: if (r_rk == 3'd4) n_state = S_MUL;
            S_MUL:  if (r_sum_st) n_state = S_DONE;
            S_DONE: if (w_ofree) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_ofree) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Height memory
    assign w_we = (r_state == S_DONE) && !r_job.is_query && r_job.wr_ok;
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_job.widx] <= r_h;
        end
        r_mq <= r_mem[w_raddr];
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_rv <= (r_state == S_READ) && (r_rk != 3'd4);
        case (r_state)
            S_IDLE: begin
                r_job <= i_job;
            end
            S_LAVG: begin
                r_avg <= w_aprod[34:19];
            end
            S_LMUL: begin
                r_h <= (w_lprod[31:8] > 24'(hti_pkg::H_MAX)) ? hti_pkg::H_MAX
                                                            : $signed(w_lprod[31:8]);
            end
            S_PREP: begin
                r_w  <= 27'(i_cfg.cols) * 27'(w_cs);
                r_ht <= 27'(i_cfg.rows) * 27'(w_cs);
            end
            S_DIV: begin
                r_gx <= w_gx;
                r_gz <= w_gz;
            end
            S_IDX: begin
                r_idxa <= 38'(w_row) * 38'($signed({1'b0, w_cp1})) + 38'(w_col);
                r_fx   <= r_gx[7:0];
                r_fz   <= r_gz[7:0];
                r_row0 <= !w_row[27];
                r_row1 <= (w_row >= -28'sd1);
                r_col0 <= !w_col[27];
                r_col1 <= (w_col >= -28'sd1);
                r_rk   <= '0;
            end
            S_READ: begin
                r_rk  <= r_rk + 3'd1;
                r_rok <= w_ok;
                r_rkd <= r_rk[1:0];
                r_sum_st <= 1'b0;
            end
            S_MUL: begin
                if (!r_sum_st) begin
                    r_pu     <= w_u * $signed({1'b0, w_wu});
                    r_pv     <= w_v * $signed({1'b0, w_wv});
                    r_p      <= w_upper ? r_cn[0] : r_cn[3];
                    r_sum_st <= 1'b1;
                end else begin
                    r_h <= (w_hq > 29'(hti_pkg::H_MAX)) ? hti_pkg::H_MAX :
                           (w_hq < 29'(hti_pkg::H_MIN)) ? hti_pkg::H_MIN : 24'(w_hq);
                end
            end
            S_DONE: begin
                if (w_ofree) begin
                    r_oh <= r_h;
                    r_oq <= r_job.is_query;
                end
            end
            default: begin
            end
        endcase
        if (r_rv) begin
            r_cn[r_rkd] <= r_rok ? r_mq : '0;
        end
    end

    assign o_valid      = r_ov;
    assign o_height_out = r_oh;
    assign o_was_query  = r_oq;

    `ASSERT_IMPL(a_pop_idle, o_pop, r_state == S_IDLE)
    `ASSERT_IMPL(a_div_lockstep, 1'b1, w_dxdone == w_dzdone)
    `ASSERT_IMPL(a_write_load, w_we, !r_job.is_query)

endmodule

[sv/heightmap_triangle_interpolation_top.sv]
// ----------------------------------------------------------------------------
// heightmap_triangle_interpolation_top
// Vertex height grid with load and triangle-interpolated height query.
// ----------------------------------------------------------------------------
// Load: queue, job register, average, scale and output register, in that order.
// Query: queue, job register, grid extent, the 36-step serial grid dividers,
//   index, four corner reads on the single read port, interpolation, output.
// One item is worked at a time; the back pops no new item until the last is done;
//   a 2-entry queue takes items while one runs, a stalled result holds the back.
// Reset (synchronous, active low) restores register defaults and empties the
//   queue; the height memory is not cleared and is undefined until loaded.

module heightmap_triangle_interpolation_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [hti_pkg::CSW-1:0]       i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [hti_pkg::CW-1:0]        i_vertex_row,
    input  logic [hti_pkg::CW-1:0]        i_vertex_column,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    input  logic signed [hti_pkg::HW-1:0] i_query_x,
    input  logic signed [hti_pkg::HW-1:0] i_query_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [hti_pkg::HW-1:0] o_height_out,
    output logic                          o_was_query
);

    logic [hti_pkg::CW-1:0]  r_cols, r_rows;
    logic [hti_pkg::CSW-1:0] r_cs;
    logic [hti_pkg::HFW-1:0] r_hf;
    hti_pkg::t_cfg           w_cfg;
    hti_pkg::t_job           w_job;
    logic                    w_job_valid, w_pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 7'd64;
            r_rows <= 7'd64;
            r_cs   <= 20'd12800;
            r_hf   <= 16'd768;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hti_pkg::REG_COLS: r_cols <= i_cfg_data[hti_pkg::CW-1:0];
                hti_pkg::REG_ROWS: r_rows <= i_cfg_data[hti_pkg::CW-1:0];
                hti_pkg::REG_CS:   r_cs   <= i_cfg_data;
                hti_pkg::REG_HF:   r_hf   <= i_cfg_data[hti_pkg::HFW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamped cell counts
    always_comb begin
        w_cfg.cols = hti_pkg::eff_cells(r_cols);
        w_cfg.rows = hti_pkg::eff_cells(r_rows);
        w_cfg.cs   = r_cs;
        w_cfg.hf   = r_hf;
    end

    hti_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_vertex_row    (i_vertex_row),
        .i_vertex_column (i_vertex_column),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_query_x       (i_query_x),
        .i_query_z       (i_query_z),
        .o_job_valid     (w_job_valid),
        .o_job           (w_job),
        .i_pop           (w_pop)
    );

    hti_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_job_valid  (w_job_valid),
        .i_job        (w_job),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_height_out (o_height_out),
        .o_was_query  (o_was_query)
    );

endmodule
